// ===== rtl/core/sfd_pkg.sv =====
// Shared types and constants of the stuffed frame deframer.
package sfd_pkg;

    localparam logic [7:0] MARK_BYTE     = 8'h01;
    localparam logic [7:0] ESC_BYTE      = 8'h1B;
    localparam logic [7:0] ESC_MASK      = 8'h7F;
    localparam logic [7:0] DISPLAY_TYPES = 8'd16;

    localparam logic KIND_WRITE     = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] frame_type;
        logic       to_display;
        logic [9:0] address;
        logic [7:0] data;
        logic [7:0] byte_count;
        logic       overflow;
    } sfd_result_t;

    // One result handed from the parser to the output stage.
    typedef struct packed {
        logic        valid;
        sfd_result_t result;
    } sfd_push_t;

endpackage

// ===== rtl/core/sfd_if.sv =====
// Channel interfaces: received byte items and result items.
interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] frame_type;
    logic       to_display;
    logic [9:0] address;
    logic [7:0] data;
    logic [7:0] byte_count;
    logic       overflow;

    modport source (output valid, output kind, output frame_type, output to_display,
                    output address, output data, output byte_count, output overflow,
                    input ready);
    modport sink   (input valid, input kind, input frame_type, input to_display,
                    input address, input data, input byte_count, input overflow,
                    output ready);
endinterface

// ===== rtl/core/sfd_parse.sv =====
// Frame parser: state registers and per-byte decode producing at most one result.
module sfd_parse
    import sfd_pkg::*;
#(
    parameter int LINE_BYTES    = 64,
    parameter int DISPLAY_LINES = 16,
    parameter int TEMP_BYTES    = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output sfd_push_t  push
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_START = 3'b010,
        MODE_DATA  = 3'b100
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] index_reg, index_next;
    logic       ovf_reg, ovf_next;

    logic [7:0]  unstuffed;
    logic        disp;
    logic [8:0]  capacity;
    logic [11:0] line_base;
    logic [11:0] addr_full;

    assign unstuffed = esc_reg ? (rx_byte & ESC_MASK) : rx_byte;
    assign disp      = (type_reg < DISPLAY_TYPES);
    assign line_base = 12'(type_reg[3:0]) * 12'(LINE_BYTES);
    assign addr_full = 12'(index_reg) + (disp ? line_base : 12'd0);

    always_comb
    begin
        if (disp)
        begin
            if ({1'b0, type_reg[3:0]} < 5'(DISPLAY_LINES))
                capacity = 9'(LINE_BYTES);
            else
                capacity = 9'd0;
        end
        else
        begin
            capacity = 9'(TEMP_BYTES);
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        type_next  = type_reg;
        index_next = index_reg;
        ovf_next   = ovf_reg;

        push.valid             = 1'b0;
        push.result.kind       = KIND_WRITE;
        push.result.frame_type = type_reg;
        push.result.to_display = disp;
        push.result.address    = 10'd0;
        push.result.data       = 8'd0;
        push.result.byte_count = 8'd0;
        push.result.overflow   = ovf_reg;

        if (accept)
        begin
            case (mode_reg)
                MODE_START:
                begin
                    if (rx_byte == ESC_BYTE)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (rx_byte != MARK_BYTE)
                    begin
                        type_next  = unstuffed;
                        esc_next   = 1'b0;
                        index_next = 8'd0;
                        ovf_next   = 1'b0;
                        mode_next  = MODE_DATA;
                    end
                end
                MODE_DATA:
                begin
                    if (rx_byte == MARK_BYTE)
                    begin
                        push.valid             = 1'b1;
                        push.result.kind       = KIND_FRAME_END;
                        push.result.byte_count = index_reg;
                        esc_next               = 1'b0;
                        mode_next              = MODE_IDLE;
                    end
                    else if (rx_byte == ESC_BYTE)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        esc_next = 1'b0;
                        if ({1'b0, index_reg} >= capacity)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            push.valid          = 1'b1;
                            push.result.address = addr_full[9:0];
                            push.result.data    = unstuffed;
                            index_next          = index_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                    mode_next = (rx_byte == MARK_BYTE) ? MODE_START : MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            esc_reg   <= 1'b0;
            type_reg  <= 8'd0;
            index_reg <= 8'd0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            type_reg  <= type_next;
            index_reg <= index_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== rtl/core/sfd_skid.sv =====
// Output register with a skid entry so the input side keeps moving under a stall.
module sfd_skid
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sfd_push_t   push,
    output logic        can_push,
    output logic        out_valid,
    input  logic        out_ready,
    output sfd_result_t out_result
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    sfd_result_t out_data_reg, out_data_next;
    sfd_result_t skid_data_reg, skid_data_next;
    logic        pop;

    assign can_push   = !skid_valid_reg;
    assign pop        = out_valid_reg && out_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push.valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push.result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push.result;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/core/stuffed_frame_deframer.sv =====
// Top level of the byte-stuffed serial frame deframer.
//
//  channel | dir | fields                                          | handshake
//  --------+-----+-------------------------------------------------+-----------
//  rx      | in  | rx_byte                                         | valid/ready
//  res     | out | kind frame_type to_display address data         | valid/ready
//          |     | byte_count overflow                             |
//
// One byte item is taken per cycle while rx.ready is high; parser state
// updates at the accepting edge and a result, if any, is registered into the
// output register, or into the skid entry behind it when res stalls. The skid
// entry keeps rx ready through one stalled result; rx.ready drops only while
// that entry is occupied. rst_n is asynchronous: the parser returns to
// waiting for a start byte and both output entries are emptied.
module stuffed_frame_deframer
    import sfd_pkg::*;
#(
    parameter int LINE_BYTES    = 64,
    parameter int DISPLAY_LINES = 16,
    parameter int TEMP_BYTES    = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    sfd_in_if.sink     rx,
    sfd_out_if.source  res
);

    sfd_push_t   push;
    sfd_result_t out_result;
    logic        can_push;
    logic        accept;

    assign rx.ready = can_push;
    assign accept   = rx.valid && can_push;

    sfd_parse #(
        .LINE_BYTES    (LINE_BYTES),
        .DISPLAY_LINES (DISPLAY_LINES),
        .TEMP_BYTES    (TEMP_BYTES)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .push    (push)
    );

    sfd_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .can_push   (can_push),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .out_result (out_result)
    );

    assign res.kind       = out_result.kind;
    assign res.frame_type = out_result.frame_type;
    assign res.to_display = out_result.to_display;
    assign res.address    = out_result.address;
    assign res.data       = out_result.data;
    assign res.byte_count = out_result.byte_count;
    assign res.overflow   = out_result.overflow;

endmodule

// ===== rtl/core/sfd_checker.sv =====
// Port-level checks on the deframer's result channel, bound to the top level.
module sfd_checker
    import sfd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       kind,
    input logic [7:0] frame_type,
    input logic       to_display,
    input logic [9:0] address,
    input logic [7:0] data,
    input logic [7:0] byte_count,
    input logic       overflow
);

    // A stalled result holds still in kind, address, data, byte_count and overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(address)
            && $stable(data) && $stable(byte_count) && $stable(overflow))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> to_display == (frame_type < DISPLAY_TYPES))
        else $error("to_display disagrees with frame_type");

    // Fields that do not belong to the result kind stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (kind == KIND_FRAME_END) ? (address == 10'd0 && data == 8'd0)
                                               : (byte_count == 8'd0))
        else $error("unused field of result not zero");

    // Temp buffer writes address the index alone, which is below 256.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_WRITE && !to_display |-> address[9:8] == 2'b00)
        else $error("temp buffer address out of range");

endmodule

bind stuffed_frame_deframer sfd_checker u_sfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .kind       (res.kind),
    .frame_type (res.frame_type),
    .to_display (res.to_display),
    .address    (res.address),
    .data       (res.data),
    .byte_count (res.byte_count),
    .overflow   (res.overflow)
);
